>>> rtl/ggs_pkg.sv
// Shared types and constants for the grid Gaussian smoother.
// No dependencies.
`default_nettype none
package ggs_pkg;
  localparam int GridCells = 4096;
  localparam int MaxRadius = 7;
  localparam int PtrW = 12;
  localparam logic [2:0] RegWidth = 3'd0;
  localparam logic [2:0] RegHeight = 3'd1;
  localparam logic [2:0] RegRadius = 3'd2;
  localparam logic [2:0] RegWLow = 3'd3;
  localparam logic [2:0] RegWHigh = 3'd4;
  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ISSUE, ST_DIV, ST_OUT
  } state_t;
  typedef struct packed {
    logic start_load;
    logic start_comp;
    logic tap_step;
    logic div_start;
    logic div_step;
    logic finish;
  } cmd_t;
  typedef struct packed {
    logic taps_done;
    logic div_done;
  } sts_t;
endpackage
`default_nettype wire

>>> rtl/ggs_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module ggs_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> rtl/ggs_ctrl.sv
// Controller state machine for the smoother.
// Depends on ggs_pkg.
`default_nettype none
module ggs_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         in_mode,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  wire ggs_pkg::sts_t sts,
  output ggs_pkg::cmd_t     cmd
);
  ggs_pkg::state_t state_r, state_nxt;
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ggs_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ggs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode) begin
            cmd.start_comp = 1'b1;
            state_nxt = ggs_pkg::ST_ISSUE;
          end else begin
            cmd.start_load = 1'b1;
            state_nxt = ggs_pkg::ST_LOAD;
          end
        end
      end
      ggs_pkg::ST_LOAD: state_nxt = ggs_pkg::ST_IDLE;
      ggs_pkg::ST_ISSUE: begin
        cmd.tap_step = 1'b1;
        if (sts.taps_done) begin
          cmd.div_start = 1'b1;
          state_nxt = ggs_pkg::ST_DIV;
        end
      end
      ggs_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ggs_pkg::ST_OUT;
      end
      ggs_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.finish = 1'b1;
          state_nxt = ggs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ggs_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/ggs_dp.sv
// Datapath: grid store, window sweep, accumulator and serial divider.
// Depends on ggs_pkg and ggs_ram.
`default_nettype none
module ggs_dp #(
  parameter int GridCells = ggs_pkg::GridCells
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [63:0]         cfg_data,
  input  wire logic signed [31:0]  in_sample,
  input  wire ggs_pkg::cmd_t       cmd,
  output ggs_pkg::sts_t            sts,
  output logic signed [31:0]       out_smoothed_value,
  output logic [11:0]              out_cell_index,
  output logic                     out_last_cell
);
  localparam int AW = $clog2(GridCells);
  logic [6:0] width_r, height_r;
  logic [2:0] radius_r;
  logic [63:0] wlo_r, whi_r;
  logic [AW-1:0] lptr_r, cptr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 7'd64; height_r <= 7'd64; radius_r <= '0;
      wlo_r <= 64'd65535; whi_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ggs_pkg::RegWidth: width_r <= cfg_data[6:0];
        ggs_pkg::RegHeight: height_r <= cfg_data[6:0];
        ggs_pkg::RegRadius: radius_r <= cfg_data[2:0];
        ggs_pkg::RegWLow: wlo_r <= cfg_data;
        ggs_pkg::RegWHigh: whi_r <= cfg_data;
        default: ;
      endcase
    end
  end
  logic [6:0] w, h;
  assign w = (width_r == 0) ? 7'd1 : (width_r > 7'd64) ? 7'd64 : width_r;
  assign h = (height_r == 0) ? 7'd1 : (height_r > 7'd64) ? 7'd64 : height_r;
  logic [12:0] prod;
  logic [16:0] cells;
  assign prod = 13'(w * h);
  assign cells = (17'(prod) > 17'(GridCells)) ? 17'(GridCells) : 17'(prod);
  logic [AW-1:0] lcur, ccur;
  assign lcur = (17'(lptr_r) >= cells) ? '0 : lptr_r;
  assign ccur = (17'(cptr_r) >= cells) ? '0 : cptr_r;
  logic [AW-1:0] lnext, cnext;
  assign lnext = (17'(lcur) + 17'd1 >= cells) ? '0 : AW'(lcur + 1'b1);
  assign cnext = (17'(ccur) + 17'd1 >= cells) ? '0 : AW'(ccur + 1'b1);

  // Cell coordinates, held during a compute.
  logic [AW-1:0] c_r;
  logic [AW-1:0] scan_r;
  logic [6:0] sx_r, sy_r;
  logic scanning_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lptr_r <= '0; cptr_r <= '0; scanning_r <= 1'b0;
    end else begin
      if (cmd.start_load) lptr_r <= lnext;
      if (cmd.start_comp) begin
        c_r <= ccur; scan_r <= '0; sx_r <= '0; sy_r <= '0;
        scanning_r <= (ccur != 0);
        cptr_r <= cnext;
      end else if (scanning_r) begin
        // Find x and y by stepping through the raster, one cell a cycle.
        if (sx_r == w - 7'd1) begin sx_r <= '0; sy_r <= sy_r + 7'd1; end
        else sx_r <= sx_r + 7'd1;
        scan_r <= AW'(scan_r + 1'b1);
        if (AW'(scan_r + 1'b1) == c_r) scanning_r <= 1'b0;
      end
    end
  end

  // Tap sweep: axis then k = 0..2r, one read per cycle.
  logic axis_r;
  logic [3:0] k_r;
  logic rv_r, rv2_r;
  logic [15:0] wt_r;
  logic signed [47:0] prod_r;
  logic pv_r;
  logic signed [63:0] num_r;
  logic [20:0] den_r;
  logic signed [7:0] p;
  logic [3:0] off;
  logic [15:0] wt;
  logic [6:0] lim, pos;
  logic inb;
  logic [12:0] idx;
  logic [3:0] kmax;
  assign kmax = {radius_r, 1'b0};
  assign pos = axis_r ? sy_r : sx_r;
  assign lim = axis_r ? h : w;
  assign p = $signed({1'b0, pos}) - $signed({5'b0, radius_r}) + $signed({4'b0, k_r});
  assign off = (k_r >= {1'b0, radius_r}) ? k_r - {1'b0, radius_r} : {1'b0, radius_r} - k_r;
  always_comb begin
    case (off[2])
      1'b0: wt = 16'(wlo_r >> {off[1:0], 4'b0});
      default: wt = 16'(whi_r >> {off[1:0], 4'b0});
    endcase
  end
  assign idx = axis_r ? 13'(p[6:0] * w + sx_r) : 13'(sy_r * w + p[6:0]);
  assign inb = !p[7] && (p[6:0] < lim) && (17'(idx) < cells);
  logic active;
  assign active = cmd.tap_step && !scanning_r && !(axis_r && k_r > kmax);
  logic [AW-1:0] raddr;
  logic [31:0] rdata;
  assign raddr = cmd.start_load ? lcur : AW'(idx);
  ggs_ram #(.Width(32), .Depth(GridCells)) u_ram (
    .clk(clk), .we(cmd.start_load), .addr(raddr), .wdata(in_sample), .rdata(rdata)
  );
  logic taps_end;
  assign taps_end = cmd.tap_step && !scanning_r && axis_r && k_r > kmax
                    && !rv_r && !rv2_r && !pv_r;
  assign sts.taps_done = taps_end;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0; rv2_r <= 1'b0; pv_r <= 1'b0;
    end else begin
      rv_r <= active && inb;
      rv2_r <= rv_r;
      pv_r <= rv2_r;
    end
    if (cmd.start_comp) begin
      axis_r <= 1'b0; k_r <= '0; num_r <= '0; den_r <= '0;
    end else begin
      if (active) begin
        if (k_r == kmax && !axis_r) begin axis_r <= 1'b1; k_r <= '0; end
        else k_r <= k_r + 4'd1;
      end
      if (rv_r) den_r <= den_r + 21'(wt_r);
      if (rv2_r) num_r <= num_r + 64'(prod_r);
    end
    wt_r <= wt;
    prod_r <= $signed({1'b0, wt_r}) * $signed(rdata);
  end

  // Restoring divider on magnitudes, one quotient bit per cycle.
  logic [63:0] mag_r, rem_r;
  logic neg_r;
  logic [6:0] cnt_r;
  logic [64:0] trial;
  assign trial = {rem_r, mag_r[63]} - {44'b0, den_r};
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_r <= num_r[63];
      mag_r <= num_r[63] ? 64'(-num_r) : 64'(num_r);
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step && cnt_r != 7'd64) begin
      if (!trial[64]) begin
        rem_r <= trial[63:0];
        mag_r <= {mag_r[62:0], 1'b1};
      end else begin
        rem_r <= {rem_r[62:0], mag_r[63]};
        mag_r <= {mag_r[62:0], 1'b0};
      end
      cnt_r <= cnt_r + 7'd1;
    end
  end
  assign sts.div_done = cnt_r == 7'd64;
  logic [63:0] q;
  assign q = (den_r == 0) ? 64'd0 : (neg_r ? 64'(-mag_r) : mag_r);
  assign out_smoothed_value = q[31:0];
  assign out_cell_index = 12'(c_r);
  assign out_last_cell = 17'(c_r) + 17'd1 >= cells;
endmodule
`default_nettype wire

>>> rtl/grid_gaussian_smoother.sv
// Top level of the grid Gaussian smoother.
// Depends on ggs_pkg, ggs_ctrl and ggs_dp.
//
// channel  direction  payload
// in       input      in_mode, in_sample
// out      output     out_smoothed_value, out_cell_index, out_last_cell
// cfg      input      cfg_index, cfg_data
//
// A load word is accepted and then passes through the load state. A compute
// word is accepted, steps through the raster one cell per cycle to locate x
// and y, sweeps up to 30 taps, drains the read pipeline, runs the serial
// divider and then waits in the output state until the result is taken.
// Reset is synchronous; the store itself is not cleared.
// One word is in flight at a time; a stalled output holds the block.
`default_nettype none
module grid_gaussian_smoother #(
  parameter int GridCells = ggs_pkg::GridCells
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_mode,
  input  wire logic signed [31:0] in_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_smoothed_value,
  output logic [11:0]             out_cell_index,
  output logic                    out_last_cell,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);
  ggs_pkg::cmd_t cmd;
  ggs_pkg::sts_t sts;
  ggs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_mode(in_mode),
    .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
    .sts(sts), .cmd(cmd)
  );
  ggs_dp #(.GridCells(GridCells)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_sample(in_sample), .cmd(cmd), .sts(sts),
    .out_smoothed_value(out_smoothed_value), .out_cell_index(out_cell_index),
    .out_last_cell(out_last_cell)
  );
endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for grid_gaussian_smoother: loads grids, requests smoothed cells
// and compares every result word against an in-bench predictor of the windowed weighted mean.
// Depends on ggs_pkg and the grid_gaussian_smoother RTL.
`timescale 1ns / 100ps
module testbench;

  typedef struct packed {
    logic signed [31:0] value;
    logic [11:0]        index;
    logic               last;
  } smooth_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic signed [31:0] in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_smoothed_value;
  logic [11:0] out_cell_index;
  logic out_last_cell;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = ggs_pkg::RegWidth;
  logic [63:0] cfg_data = '0;

  grid_gaussian_smoother dut (.*);

  always #1 clk = ~clk;

  logic signed [31:0] cell_mem [ggs_pkg::GridCells];
  int unsigned load_ptr, comp_ptr;
  logic [6:0] cur_width, cur_height;
  logic [2:0] cur_radius;
  logic [63:0] cur_wlow, cur_whigh;
  smooth_word_t pending_cells[$];
  int mismatches = 0;
  int words_sent = 0;
  int cells_checked = 0;
  int burst_left = 0;
  int stall_style = 0;

  function automatic int unsigned dim_of(logic [6:0] v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  function automatic int unsigned grid_cells();
    int unsigned n;
    n = dim_of(cur_width) * dim_of(cur_height);
    return (n > ggs_pkg::GridCells) ? ggs_pkg::GridCells : n;
  endfunction

  function automatic longint tap_of(int unsigned off);
    logic [63:0] lanes;
    lanes = (off < 4) ? cur_wlow : cur_whigh;
    return longint'(lanes[16 * (off % 4) +: 16]);
  endfunction

  function automatic smooth_word_t smooth_cell();
    smooth_word_t res;
    int unsigned cells, w, h, c, x, y, pos, lim, off, idx;
    int r, p;
    longint num, den, wt, q;
    cells = grid_cells();
    w = dim_of(cur_width);
    h = dim_of(cur_height);
    r = cur_radius;
    num = 0;
    den = 0;
    if (comp_ptr >= cells) comp_ptr = 0;
    c = comp_ptr;
    x = c % w;
    y = c / w;
    for (int axis = 0; axis < 2; axis++) begin
      pos = (axis == 0) ? x : y;
      lim = (axis == 0) ? w : h;
      for (int k = 0; k <= 2 * r; k++) begin
        p = int'(pos) - r + k;
        off = (k >= r) ? k - r : r - k;
        if (p < 0 || p >= int'(lim)) continue;
        idx = (axis == 0) ? y * w + p : p * w + x;
        if (idx >= cells) continue;
        wt = tap_of(off);
        num += wt * longint'(cell_mem[idx]);
        den += wt;
      end
    end
    q = (den == 0) ? 0 : num / den;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    res.value = q[31:0];
    res.index = c[11:0];
    res.last = (c + 1 >= cells);
    comp_ptr = (c + 1 >= cells) ? 0 : c + 1;
    return res;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      ggs_pkg::RegWidth:  cur_width = data[6:0];
      ggs_pkg::RegHeight: cur_height = data[6:0];
      ggs_pkg::RegRadius: cur_radius = data[2:0];
      ggs_pkg::RegWLow:   cur_wlow = data;
      ggs_pkg::RegWHigh:  cur_whigh = data;
      default: ;
    endcase
  endtask

  task automatic send_word(logic mode, logic signed [31:0] sample);
    int unsigned cells;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_mode <= mode;
    in_sample <= sample;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    words_sent++;
    if (mode == 1'b0) begin
      cells = grid_cells();
      if (load_ptr >= cells) load_ptr = 0;
      cell_mem[load_ptr] = sample;
      load_ptr = (load_ptr + 1 >= cells) ? 0 : load_ptr + 1;
    end else begin
      pending_cells.push_back(smooth_cell());
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_weights();
    logic [63:0] lanes;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 3))
        0: lanes[16 * i +: 16] = 16'h0000;
        1: lanes[16 * i +: 16] = 16'hffff;
        default: lanes[16 * i +: 16] = 16'($urandom);
      endcase
    end
    return lanes;
  endfunction

  // Loads a complete grid, then requests smoothed cells with stray loads mixed in.
  task automatic run_grid(logic [6:0] w, logic [6:0] h, logic [2:0] r,
                          logic [63:0] wl, logic [63:0] wh, int n_comp, int noise_pct);
    int unsigned cells;
    write_reg(ggs_pkg::RegWidth, {57'd0, w});
    write_reg(ggs_pkg::RegHeight, {57'd0, h});
    write_reg(ggs_pkg::RegRadius, {61'd0, r});
    write_reg(ggs_pkg::RegWLow, wl);
    write_reg(ggs_pkg::RegWHigh, wh);
    cells = grid_cells();
    for (int i = 0; i < cells; i++) send_word(1'b0, pick_sample());
    for (int i = 0; i < n_comp; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_word(1'b0, pick_sample());
      send_word(1'b1, $urandom);
    end
    drain();
  endtask

  task automatic test_single_cell();
    stall_style = 0;
    run_grid(7'd1, 7'd1, 3'd7, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 3, 50);
  endtask

  task automatic test_zero_weights();
    stall_style = 1;
    run_grid(7'd2, 7'd2, 3'd3, 64'd0, 64'hffff_0000_0000_0000, 4, 0);
  endtask

  task automatic test_full_radius_edges();
    stall_style = 2;
    run_grid(7'd3, 7'd2, 3'd7, 64'hffff_ffff_ffff_ffff, 64'h0001_8000_ffff_0001, 7, 0);
  endtask

  task automatic test_random_grids();
    for (int ph = 0; ph < 4; ph++) begin
      stall_style = $urandom_range(0, 2);
      run_grid(7'($urandom_range(1, 8)), 7'($urandom_range(1, 6)), 3'($urandom),
               pick_weights(), pick_weights(), $urandom_range(6, 20),
               $urandom_range(0, 30));
    end
  endtask

  task automatic test_out_of_range_sizes();
    stall_style = 1;
    run_grid(7'd127, 7'd0, 3'd2, pick_weights(), pick_weights(), 8, 10);
    run_grid(7'd0, 7'd100, 3'd5, pick_weights(), pick_weights(), 10, 10);
  endtask

  task automatic test_wide_grid();
    stall_style = 0;
    run_grid(7'd64, 7'd2, 3'd7, pick_weights(), pick_weights(), 3, 0);
  endtask

  always @(posedge clk) begin
    case (stall_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(negedge clk) begin
    smooth_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: cell %0d", out_cell_index);
      end else begin
        want = pending_cells.pop_front();
        cells_checked++;
        if (out_smoothed_value !== want.value || out_cell_index !== want.index ||
            out_last_cell !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected value %0d cell %0d last %0b, got %0d cell %0d last %0b",
                     want.value, want.index, want.last,
                     out_smoothed_value, out_cell_index, out_last_cell);
        end
      end
    end
  end

  initial begin
    load_ptr = 0;
    comp_ptr = 0;
    cur_width = 7'd64;
    cur_height = 7'd64;
    cur_radius = 3'd0;
    cur_wlow = 64'd65535;
    cur_whigh = 64'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_cell();
    test_zero_weights();
    test_full_radius_edges();
    test_random_grids();
    test_out_of_range_sizes();
    test_wide_grid();
    if (pending_cells.size() != 0) mismatches++;
    $display("Sent %0d words and checked %0d smoothed cells on grids from 1x1 to 64 wide.",
             words_sent, cells_checked);
    $display("Radius, weights, sizes out of range and output stalls were all varied.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

>>> grid_gaussian_smoother.f
rtl/ggs_pkg.sv
rtl/ggs_ram.sv
rtl/ggs_ctrl.sv
rtl/ggs_dp.sv
rtl/grid_gaussian_smoother.sv
tb/sv/testbench.sv
